FILE: rtl/infix_to_postfix_converter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the infix-to-postfix converter modules.
// Each macro expects i_clk and i_rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define ITP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itp: same-cycle check failed");

// Next-cycle implication.
`define ITP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itp: next-cycle check failed");

`endif

FILE: rtl/itp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itp_pkg
// Types, character codes and sizes shared by the infix-to-postfix converter.
// ---------------------------------------------------------------------------
package itp_pkg;

    // operator stack
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TERM   = 8'h00;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    typedef enum logic [2:0] {
        K_OTHER  = 3'd0,
        K_DIGIT  = 3'd1,
        K_LPAREN = 3'd2,
        K_RPAREN = 3'd3,
        K_MULDIV = 3'd4,
        K_ADDSUB = 3'd5,
        K_END    = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic [1:0] error_code;
    } t_out_item;

    // classified command, front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       hash;   // close an open digit run first
    } t_cmd;

endpackage

FILE: rtl/itp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itp_front
// Accepts input beats, classifies each character and tracks open digit runs.
// ---------------------------------------------------------------------------
module itp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  itp_pkg::t_in_item i_data,
    input  logic             i_cmd_full,
    output logic             o_cmd_push,
    output itp_pkg::t_cmd    o_cmd
);

    logic r_in_number;
    logic n_in_number;
    logic is_digit;

    assign o_ready    = !i_cmd_full;
    assign o_cmd_push = i_valid && !i_cmd_full;
    assign is_digit   = (i_data.char_in >= itp_pkg::CH_ZERO) &&
                        (i_data.char_in <= itp_pkg::CH_NINE);

    always_comb begin
        o_cmd.ch   = i_data.char_in;
        o_cmd.hash = r_in_number && (i_data.end_of_expr || !is_digit);
        priority if (i_data.end_of_expr) begin
            o_cmd.kind = itp_pkg::K_END;
        end else if (is_digit) begin
            o_cmd.kind = itp_pkg::K_DIGIT;
        end else if (i_data.char_in == itp_pkg::CH_LPAREN) begin
            o_cmd.kind = itp_pkg::K_LPAREN;
        end else if (i_data.char_in == itp_pkg::CH_RPAREN) begin
            o_cmd.kind = itp_pkg::K_RPAREN;
        end else if (i_data.char_in == itp_pkg::CH_STAR ||
                     i_data.char_in == itp_pkg::CH_SLASH) begin
            o_cmd.kind = itp_pkg::K_MULDIV;
        end else if (i_data.char_in == itp_pkg::CH_PLUS ||
                     i_data.char_in == itp_pkg::CH_MINUS) begin
            o_cmd.kind = itp_pkg::K_ADDSUB;
        end else begin
            o_cmd.kind = itp_pkg::K_OTHER;
        end
    end

    // a run stays open only across consecutive digits
    assign n_in_number = o_cmd_push ? (!i_data.end_of_expr && is_digit) : r_in_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
        end else begin
            r_in_number <= n_in_number;
        end
    end

endmodule

FILE: rtl/itp_cmd_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itp_cmd_fifo
// Short command queue that decouples the classifier from the stack engine.
// ---------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module itp_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  itp_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output itp_pkg::t_cmd o_cmd
);

    itp_pkg::t_cmd                   r_q [itp_pkg::Q_DEPTH];
    logic [itp_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [itp_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [itp_pkg::Q_CNT_W-1:0]     r_count;
    logic [itp_pkg::Q_PTR_W-1:0]     n_wr_ptr;
    logic [itp_pkg::Q_PTR_W-1:0]     n_rd_ptr;
    logic [itp_pkg::Q_CNT_W-1:0]     n_count;

    assign o_full  = (r_count == itp_pkg::Q_CNT_W'(itp_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == itp_pkg::Q_PTR_W'(itp_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + itp_pkg::Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == itp_pkg::Q_PTR_W'(itp_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + itp_pkg::Q_PTR_W'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + itp_pkg::Q_CNT_W'(1);
            2'b01:   n_count = r_count - itp_pkg::Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    `ITP_ASSERT_NOW(a_q_no_overflow, i_push, !o_full)
    `ITP_ASSERT_NOW(a_q_no_underflow, i_pop, o_valid)
    `ITP_ASSERT_NOW(a_q_count_bound, 1'b1, r_count <= itp_pkg::Q_CNT_W'(itp_pkg::Q_DEPTH))

endmodule

FILE: rtl/itp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itp_back
// Stack engine: runs one classified command at a time against the operator
// stack, one push or pop per unstalled cycle, and drives the result channel.
// ---------------------------------------------------------------------------
`include "infix_to_postfix_converter_assert.svh"

module itp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  itp_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output itp_pkg::t_out_item o_data
);

    // operator stack: memory with registered top-of-stack read
    logic [7:0]                r_stack_mem [itp_pkg::STACK_DEPTH];
    logic [7:0]                r_top;
    logic [itp_pkg::CNT_W-1:0] r_count;
    logic [itp_pkg::CNT_W-1:0] n_count;
    logic [itp_pkg::CNT_W-1:0] cnt_m1;
    logic [itp_pkg::PTR_W-1:0] rd_addr;

    logic [1:0]                r_sticky;
    logic                      r_hash_done;

    // one result held back until it is known whether it closes its beat
    logic                      r_pend_valid;
    itp_pkg::t_out_item        r_pend;
    logic                      r_ovalid;
    itp_pkg::t_out_item        r_odata;

    logic       out_free;
    logic       pend_move;
    logic       step;
    logic       cnt_nz;
    logic       full;
    logic       top_lp;
    logic       top_md;

    logic       emit;
    logic [7:0] e_ch;
    logic [1:0] e_err;
    logic       do_pop;
    logic       want_push;
    logic       finish;
    logic       hash_emit;
    logic       clr_err;
    logic [1:0] set_code;
    logic       push_ok;

    assign out_free  = !r_ovalid || i_ready;
    assign pend_move = r_pend_valid && out_free;
    assign step      = i_cmd_valid && (!r_pend_valid || out_free);
    assign cnt_nz    = (r_count != '0);
    assign full      = (r_count >= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    assign top_lp    = (r_top == itp_pkg::CH_LPAREN);
    assign top_md    = (r_top == itp_pkg::CH_STAR) || (r_top == itp_pkg::CH_SLASH);

    always_comb begin
        emit      = 1'b0;
        e_ch      = itp_pkg::CH_TERM;
        e_err     = itp_pkg::ERR_NONE;
        do_pop    = 1'b0;
        want_push = 1'b0;
        finish    = 1'b0;
        hash_emit = 1'b0;
        clr_err   = 1'b0;
        set_code  = itp_pkg::ERR_NONE;
        if (i_cmd.hash && !r_hash_done) begin
            // close the digit run before anything else
            emit      = 1'b1;
            e_ch      = itp_pkg::CH_HASH;
            hash_emit = 1'b1;
        end else begin
            unique case (i_cmd.kind)
                itp_pkg::K_END: begin
                    if (cnt_nz) begin
                        emit   = 1'b1;
                        e_ch   = r_top;
                        do_pop = 1'b1;
                    end else begin
                        emit    = 1'b1;
                        e_ch    = itp_pkg::CH_TERM;
                        e_err   = r_sticky;
                        clr_err = 1'b1;
                        finish  = 1'b1;
                    end
                end
                itp_pkg::K_DIGIT: begin
                    emit   = 1'b1;
                    e_ch   = i_cmd.ch;
                    finish = 1'b1;
                end
                itp_pkg::K_LPAREN: begin
                    want_push = 1'b1;
                    finish    = 1'b1;
                end
                itp_pkg::K_RPAREN: begin
                    if (cnt_nz && !top_lp) begin
                        emit   = 1'b1;
                        e_ch   = r_top;
                        do_pop = 1'b1;
                    end else if (cnt_nz) begin
                        // drop the matching '('
                        do_pop = 1'b1;
                        finish = 1'b1;
                    end else begin
                        set_code = itp_pkg::ERR_UNMATCHED;
                        finish   = 1'b1;
                    end
                end
                itp_pkg::K_MULDIV: begin
                    if (cnt_nz && top_md) begin
                        emit   = 1'b1;
                        e_ch   = r_top;
                        do_pop = 1'b1;
                    end else begin
                        want_push = 1'b1;
                        finish    = 1'b1;
                    end
                end
                itp_pkg::K_ADDSUB: begin
                    if (cnt_nz && !top_lp) begin
                        emit   = 1'b1;
                        e_ch   = r_top;
                        do_pop = 1'b1;
                    end else begin
                        want_push = 1'b1;
                        finish    = 1'b1;
                    end
                end
                default: begin
                    finish = 1'b1;
                end
            endcase
            if (want_push && full) begin
                set_code = itp_pkg::ERR_OVERFLOW;
            end
        end
    end

    assign push_ok   = step && want_push && !full;
    assign o_cmd_pop = step && finish;

    always_comb begin
        n_count = r_count;
        if (step && do_pop) begin
            n_count = r_count - itp_pkg::CNT_W'(1);
        end else if (push_ok) begin
            n_count = r_count + itp_pkg::CNT_W'(1);
        end
    end

    assign cnt_m1  = n_count - itp_pkg::CNT_W'(1);
    assign rd_addr = (n_count == '0) ? '0 : cnt_m1[itp_pkg::PTR_W-1:0];

    // read the next top every cycle; bypass a fresh push
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_stack_mem[r_count[itp_pkg::PTR_W-1:0]] <= i_cmd.ch;
            r_top <= i_cmd.ch;
        end else begin
            r_top <= r_stack_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sticky    <= itp_pkg::ERR_NONE;
            r_hash_done <= 1'b0;
        end else begin
            r_count <= n_count;
            if (step && clr_err) begin
                r_sticky <= itp_pkg::ERR_NONE;
            end else if (step && set_code != itp_pkg::ERR_NONE &&
                         r_sticky == itp_pkg::ERR_NONE) begin
                r_sticky <= set_code;
            end
            if (step && finish) begin
                r_hash_done <= 1'b0;
            end else if (step && hash_emit) begin
                r_hash_done <= 1'b1;
            end
        end
    end

    // hold stage: valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (step && emit) begin
            r_pend_valid <= 1'b1;
        end else if (pend_move) begin
            r_pend_valid <= 1'b0;
        end
    end

    // hold stage: payload; a silent finish marks the held result as last
    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_pend.char_out   <= e_ch;
            r_pend.run_last   <= finish;
            r_pend.error_code <= e_err;
        end else if (step && finish && r_pend_valid) begin
            r_pend.run_last <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (pend_move) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_odata.char_out   <= r_pend.char_out;
            r_odata.run_last   <= r_pend.run_last || (step && finish && !emit);
            r_odata.error_code <= r_pend.error_code;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    `ITP_ASSERT_NOW(a_stack_bound, 1'b1, r_count <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
    `ITP_ASSERT_NEXT(a_term_clears, step && emit && clr_err, r_count == '0 && r_sticky == itp_pkg::ERR_NONE)
    `ITP_ASSERT_NOW(a_err_on_term, r_ovalid && r_odata.error_code != itp_pkg::ERR_NONE, r_odata.run_last && r_odata.char_out == itp_pkg::CH_TERM)
    `ITP_ASSERT_NOW(a_pop_nonempty, step && do_pop, cnt_nz)

endmodule

FILE: rtl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// infix_to_postfix_converter
// Streaming shunting-yard converter from infix characters to postfix.
// ---------------------------------------------------------------------------
// One infix character arrives per input beat; each beat releases zero or
// more postfix result beats, with run_last set on the last one of them. A
// classifier takes one beat per cycle into a two-entry command queue while
// the queue has room. Behind it the stack engine emits a digit, pushes '('
// and drops an ignored character; for ')', an operator or the end item it
// pops and emits stacked operators one at a time, then finishes the entry.
// A beat that closes a digit run first emits '#'. The top of the operator
// stack is read through a register. The end item empties the stack and
// emits a 0 terminator carrying the first error of the expression
// (1 overflow, 2 unmatched ')').
// ---------------------------------------------------------------------------
module infix_to_postfix_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  itp_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output itp_pkg::t_out_item o_data
);

    itp_pkg::t_cmd front_cmd;
    itp_pkg::t_cmd head_cmd;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_valid;
    logic          cmd_pop;

    itp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (front_cmd)
    );

    itp_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    itp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
